### design/zta_pkg.sv
// ---------------------------------------------------------------------------
// zta_pkg
// Types, widths and helpers shared by the zone timing aggregator.
// ---------------------------------------------------------------------------
package zta_pkg;

   localparam int KEY_BITS        = 16;
   localparam int TIME_W          = 63;
   localparam int TOTAL_W         = 64;
   localparam int CALLS_W         = 14;
   localparam int LOST_W          = 32;
   localparam int DEF_MAX_ZONES   = 32;
   localparam int DEF_EVENT_CAP   = 8192;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERD,
      ST_ECMP,
      ST_UPD,
      ST_APPEND,
      ST_SRD,
      ST_SCMP,
      ST_FETCH,
      ST_LOAD,
      ST_OUT
   } zta_state_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic [TOTAL_W-1:0]  total;
      logic [CALLS_W-1:0]  calls;
   } zta_entry_type;

   function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                  input logic [TOTAL_W-1:0] b);
      logic [TOTAL_W-1:0] r;
      r = a + b;
      if (a[TOTAL_W-1] == b[TOTAL_W-1] && r[TOTAL_W-1] != a[TOTAL_W-1]) begin
         r = a[TOTAL_W-1] ? {1'b1, {(TOTAL_W-1){1'b0}}} : {1'b0, {(TOTAL_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

### design/zta_if.sv
// ---------------------------------------------------------------------------
// zta_if
// Request and response channels of the zone timing aggregator.
// ---------------------------------------------------------------------------
interface zta_req_if;
   import zta_pkg::*;
   logic                valid;
   logic                ready;
   logic                action;
   logic [KEY_BITS-1:0] zone_id;
   logic [TIME_W-1:0]   start_time;
   logic [TIME_W-1:0]   end_time;
   modport source (output valid, action, zone_id, start_time, end_time, input ready);
   modport sink   (input valid, action, zone_id, start_time, end_time, output ready);
endinterface

interface zta_rsp_if;
   import zta_pkg::*;
   logic                valid;
   logic                ready;
   logic                zone_valid;
   logic [KEY_BITS-1:0] zone_key;
   logic [TOTAL_W-1:0]  total_ns;
   logic [CALLS_W-1:0]  call_count;
   logic [LOST_W-1:0]   dropped_events;
   logic                last;
   modport source (output valid, zone_valid, zone_key, total_ns, call_count,
                   dropped_events, last, input ready);
   modport sink   (input valid, zone_valid, zone_key, total_ns, call_count,
                   dropped_events, last, output ready);
endinterface

### design/zone_timing_aggregator.sv
// ---------------------------------------------------------------------------
// zone_timing_aggregator
// Per-zone timing totals over a frame, reported sorted by descending total.
// ---------------------------------------------------------------------------
// Event: counted lost when the buffer is full, appended when the table is empty, else
//   accepted, table entries searched in turn, and the match updated or the new key
//   appended (a new key on a full table is counted lost). Frame mark: accepted, then
//   each result is scanned, fetched, loaded and output, waiting for rsp ready; an
//   empty frame gives its one word. One word in flight at a time; one table read port.
// Synchronous reset clears counters and sequencer; table stays undefined until written.
module zone_timing_aggregator #(
   parameter int MAX_ZONE_ENTRIES = zta_pkg::DEF_MAX_ZONES,
   parameter int EVENT_CAPACITY   = zta_pkg::DEF_EVENT_CAP
) (
   input  logic      clock,
   input  logic      reset,
   zta_req_if.sink   req_chan,
   zta_rsp_if.source rsp_chan
);
   import zta_pkg::*;

   localparam int ADDR_W = (MAX_ZONE_ENTRIES > 1) ? $clog2(MAX_ZONE_ENTRIES) : 1;
   localparam int CNT_W  = ADDR_W + 1;
   localparam int HELD_W = $clog2(EVENT_CAPACITY + 1);

   zta_state_type state_ff, state_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] best_idx_ff, best_idx_in;
   logic [TOTAL_W-1:0] best_ff, best_in;
   logic have_ff, have_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [HELD_W-1:0] held_ff, held_in;
   logic [LOST_W-1:0] lost_ff, lost_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [TOTAL_W-1:0] dur_ff, dur_in;
   logic [MAX_ZONE_ENTRIES-1:0] emitted_ff, emitted_in;
   logic rzv_ff, rzv_in, rlast_ff, rlast_in;
   logic [KEY_BITS-1:0] rkey_ff, rkey_in;
   logic [TOTAL_W-1:0] rtotal_ff, rtotal_in;
   logic [CALLS_W-1:0] rcalls_ff, rcalls_in;

   logic wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   zta_entry_type wr_data, rd_data;
   logic req_fire, rsp_fire;
   logic [CNT_W-1:0] addr_next;
   logic [LOST_W-1:0] lost_inc;

   zta_table #(.DEPTH(MAX_ZONE_ENTRIES), .ADDR_W(ADDR_W)) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = (state_ff == ST_OUT);
   assign rsp_chan.zone_valid = rzv_ff;
   assign rsp_chan.zone_key = rkey_ff;
   assign rsp_chan.total_ns = rtotal_ff;
   assign rsp_chan.call_count = rcalls_ff;
   assign rsp_chan.dropped_events = lost_ff;
   assign rsp_chan.last = rlast_ff;

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign rsp_fire  = rsp_chan.valid && rsp_chan.ready;
   assign addr_next = {1'b0, addr_ff} + 1'b1;
   assign lost_inc  = (lost_ff == '1) ? lost_ff : lost_ff + 1'b1;
   assign rd_addr   = (state_ff == ST_FETCH) ? best_idx_ff : addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff  <= '0;
         held_ff  <= '0;
         lost_ff  <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         held_ff  <= held_in;
         lost_ff  <= lost_in;
      end
      addr_ff     <= addr_in;
      best_idx_ff <= best_idx_in;
      best_ff     <= best_in;
      have_ff     <= have_in;
      k_ff        <= k_in;
      key_ff      <= key_in;
      dur_ff      <= dur_in;
      emitted_ff  <= emitted_in;
      rzv_ff      <= rzv_in;
      rlast_ff    <= rlast_in;
      rkey_ff     <= rkey_in;
      rtotal_ff   <= rtotal_in;
      rcalls_ff   <= rcalls_in;
   end

   always_comb begin
      state_in    = state_ff;
      addr_in     = addr_ff;
      best_idx_in = best_idx_ff;
      best_in     = best_ff;
      have_in     = have_ff;
      used_in     = used_ff;
      k_in        = k_ff;
      held_in     = held_ff;
      lost_in     = lost_ff;
      key_in      = key_ff;
      dur_in      = dur_ff;
      emitted_in  = emitted_ff;
      rzv_in      = rzv_ff;
      rlast_in    = rlast_ff;
      rkey_in     = rkey_ff;
      rtotal_in   = rtotal_ff;
      rcalls_in   = rcalls_ff;
      wr_en       = 1'b0;
      wr_addr     = addr_ff;
      wr_data     = '{key: key_ff, total: dur_ff, calls: CALLS_W'(1)};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (!req_chan.action) begin
                  if (held_ff >= HELD_W'(EVENT_CAPACITY)) begin
                     lost_in = lost_inc;
                  end else begin
                     held_in = held_ff + 1'b1;
                     key_in  = req_chan.zone_id;
                     dur_in  = {1'b0, req_chan.end_time} - {1'b0, req_chan.start_time};
                     addr_in = '0;
                     state_in = (used_ff == '0) ? ST_APPEND : ST_ERD;
                  end
               end else if (used_ff == '0) begin
                  rzv_in    = 1'b0;
                  rkey_in   = '0;
                  rtotal_in = '0;
                  rcalls_in = '0;
                  rlast_in  = 1'b1;
                  state_in  = ST_OUT;
               end else begin
                  emitted_in = '0;
                  k_in       = '0;
                  addr_in    = '0;
                  have_in    = 1'b0;
                  state_in   = ST_SRD;
               end
            end
         end
         ST_ERD: state_in = ST_ECMP;
         ST_ECMP: begin
            if (rd_data.key == key_ff) begin
               state_in = ST_UPD;
            end else if (addr_next < used_ff) begin
               addr_in  = addr_next[ADDR_W-1:0];
               state_in = ST_ERD;
            end else if (used_ff < CNT_W'(MAX_ZONE_ENTRIES)) begin
               state_in = ST_APPEND;
            end else begin
               lost_in  = lost_inc;
               state_in = ST_IDLE;
            end
         end
         ST_UPD: begin
            wr_en = 1'b1;
            wr_data.total = sat_add(rd_data.total, dur_ff);
            wr_data.calls = (rd_data.calls == '1) ? rd_data.calls : rd_data.calls + 1'b1;
            state_in = ST_IDLE;
         end
         ST_APPEND: begin
            wr_en    = 1'b1;
            wr_addr  = used_ff[ADDR_W-1:0];
            used_in  = used_ff + 1'b1;
            state_in = ST_IDLE;
         end
         ST_SRD: state_in = ST_SCMP;
         ST_SCMP: begin
            // strict compare keeps the earliest entry on a tie
            if (!emitted_ff[addr_ff] &&
                (!have_ff || $signed(rd_data.total) > $signed(best_ff))) begin
               have_in     = 1'b1;
               best_in     = rd_data.total;
               best_idx_in = addr_ff;
            end
            if (addr_next < used_ff) begin
               addr_in  = addr_next[ADDR_W-1:0];
               state_in = ST_SRD;
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: state_in = ST_LOAD;
         ST_LOAD: begin
            rzv_in    = 1'b1;
            rkey_in   = rd_data.key;
            rtotal_in = rd_data.total;
            rcalls_in = rd_data.calls;
            rlast_in  = ((k_ff + 1'b1) == used_ff);
            emitted_in[best_idx_ff] = 1'b1;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_fire) begin
               if (rlast_ff) begin
                  used_in  = '0;
                  held_in  = '0;
                  lost_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  addr_in  = '0;
                  have_in  = 1'b0;
                  state_in = ST_SRD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(MAX_ZONE_ENTRIES))
      else $error("zone count beyond table depth");

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= HELD_W'(EVENT_CAPACITY))
      else $error("held events beyond capacity");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.zone_valid |-> rsp_chan.last && used_ff == '0)
      else $error("empty-frame word not final");

   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_chan.last |=> used_ff == '0 && lost_ff == '0 && held_ff == '0)
      else $error("frame state not cleared after report");

   a_load_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |-> have_ff && !emitted_ff[best_idx_ff])
      else $error("selected zone already reported");

endmodule

### design/zta_table.sv
// ---------------------------------------------------------------------------
// zta_table
// Zone table memory: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module zta_table #(
   parameter int DEPTH  = zta_pkg::DEF_MAX_ZONES,
   parameter int ADDR_W = 5
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  zta_pkg::zta_entry_type wr_data,
   input  logic [ADDR_W-1:0]     rd_addr,
   output zta_pkg::zta_entry_type rd_data
);
   import zta_pkg::*;

   zta_entry_type mem [DEPTH];
   zta_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
